// ===== rtl/spo2_ratio_and_quality_tracker_unit_defines.svh =====
// ----------------------------------------------------------------------------
// spo2_ratio_and_quality_tracker_unit_defines
// Assertion macros shared by the ratio/quality tracker RTL.
// ----------------------------------------------------------------------------
`ifndef SPO2_RATIO_AND_QUALITY_TRACKER_UNIT_DEFINES_SVH
`define SPO2_RATIO_AND_QUALITY_TRACKER_UNIT_DEFINES_SVH

// Clocked check, masked while reset is held.
`define SPO2RQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define SPO2RQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/spo2rq_pkg.sv =====
// ----------------------------------------------------------------------------
// spo2rq_pkg
// Widths, register indexes, reset values and codes of the ratio tracker.
// ----------------------------------------------------------------------------
package spo2rq_pkg;

    localparam int AC_BITS    = 16;
    localparam int DC_BITS    = 18;
    localparam int PROD_BITS  = AC_BITS + DC_BITS;
    // ratio scale of 1000 needs 10 more bits
    localparam int NUM_BITS   = PROD_BITS + 10;
    localparam int RATIO_BITS = 16;
    localparam int CNT_BITS   = $clog2(NUM_BITS);
    localparam int QUAL_BITS  = 8;
    localparam int SHIFT_BITS = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [1:0] balance_t;

    localparam balance_t BAL_UNKNOWN = 2'd0;
    localparam balance_t BAL_LOW     = 2'd1;
    localparam balance_t BAL_OK      = 2'd2;
    localparam balance_t BAL_HIGH    = 2'd3;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_AC_LEVEL  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUALITY_SHIFT = 2'd3;

    localparam logic [RATIO_BITS-1:0] LOW_LIMIT_RST     = 16'd500;
    localparam logic [RATIO_BITS-1:0] HIGH_LIMIT_RST    = 16'd2000;
    localparam logic [AC_BITS-1:0]    MIN_AC_LEVEL_RST  = AC_BITS'(2);
    localparam logic [SHIFT_BITS-1:0] QUALITY_SHIFT_RST = 3'd2;

    localparam logic [RATIO_BITS-1:0] RATIO_MAX = '1;

endpackage

// ===== rtl/spo2_ratio_and_quality_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// spo2_ratio_and_quality_tracker_unit
// Quality slew and smoothed red/IR ratio tracker for a pulse oximeter.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per sensor frame. s_op = 1 clears all tracker
//   state; s_op = 0 carries red/IR AC RMS, DC levels and a raw quality score.
//   m_* channel: exactly one result beat per input beat, showing the tracker
//   state after that frame (quality, smoothed ratio x1000, ratio_ok, balance).
//   cfg_* channel: register writes (0 low_limit, 1 high_limit,
//   2 min_ac_level, 3 quality_shift), always ready; the user must write
//   them only while idle, as the block does not enforce it.
// Sequencing:
//   Clear and invalid frames go straight to the publish step (S_DONE);
//   valid frames pass the 44-step bit-serial divider (44 = width of
//   red_ac*ir_level*1000) plus 2 shared-multiplier passes, scaling,
//   rounding-add, smoothing and classify steps. One frame is in work at
//   a time: s_ready is high only when idle, after the result is published.
// Reset: aresetn (sync, active low) restores register defaults
//   (500, 2000, 2, 2), zeroes the tracker state and drops m_valid.
// Stall: the result sits in an output register; a new frame may be taken
//   while it waits, but that frame's result holds until m_ready frees it.
// ----------------------------------------------------------------------------
`include "spo2_ratio_and_quality_tracker_unit_defines.svh"

module spo2_ratio_and_quality_tracker_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // input frames
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_op,
    input  logic [spo2rq_pkg::AC_BITS-1:0]          s_red_ac,
    input  logic [spo2rq_pkg::AC_BITS-1:0]          s_ir_ac,
    input  logic [spo2rq_pkg::DC_BITS-1:0]          s_red_level,
    input  logic [spo2rq_pkg::DC_BITS-1:0]          s_ir_level,
    input  logic [spo2rq_pkg::QUAL_BITS-1:0]        s_raw_score,
    // results
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [spo2rq_pkg::QUAL_BITS-1:0]        m_quality,
    output logic [spo2rq_pkg::RATIO_BITS-1:0]       m_ratio,
    output logic                                    m_ratio_ok,
    output logic [1:0]                              m_balance,
    // register writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [spo2rq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [spo2rq_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL_P = 3'd1;  // red_ac * ir_level
    localparam logic [2:0] S_MUL_D = 3'd2;  // ir_ac * red_level
    localparam logic [2:0] S_SCALE = 3'd3;  // numerator * 1000
    localparam logic [2:0] S_ADD   = 3'd4;  // + den/2, launch divide
    localparam logic [2:0] S_DIV   = 3'd5;  // wait divider, then smooth
    localparam logic [2:0] S_CLASS = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;

    // configuration
    logic [spo2rq_pkg::RATIO_BITS-1:0] low_limit_reg, low_limit_next;
    logic [spo2rq_pkg::RATIO_BITS-1:0] high_limit_reg, high_limit_next;
    logic [spo2rq_pkg::AC_BITS-1:0]    min_ac_reg, min_ac_next;
    logic [spo2rq_pkg::SHIFT_BITS-1:0] qshift_reg, qshift_next;

    // tracker state
    logic [spo2rq_pkg::QUAL_BITS-1:0]  quality_reg, quality_next;
    logic [spo2rq_pkg::RATIO_BITS-1:0] ratio_reg, ratio_next;
    logic                              valid_reg, valid_next;
    spo2rq_pkg::balance_t              balance_reg, balance_next;

    // operands and intermediates
    logic [spo2rq_pkg::AC_BITS-1:0]    red_ac_reg, red_ac_next;
    logic [spo2rq_pkg::AC_BITS-1:0]    ir_ac_reg, ir_ac_next;
    logic [spo2rq_pkg::DC_BITS-1:0]    red_lvl_reg, red_lvl_next;
    logic [spo2rq_pkg::DC_BITS-1:0]    ir_lvl_reg, ir_lvl_next;
    logic [spo2rq_pkg::PROD_BITS-1:0]  prod_reg, prod_next;
    logic [spo2rq_pkg::PROD_BITS-1:0]  den_reg, den_next;
    logic [spo2rq_pkg::NUM_BITS-1:0]   num_reg, num_next;

    // output register
    logic                              m_valid_reg, m_valid_next;
    logic [spo2rq_pkg::QUAL_BITS-1:0]  m_quality_reg, m_quality_next;
    logic [spo2rq_pkg::RATIO_BITS-1:0] m_ratio_reg, m_ratio_next;
    logic                              m_ratio_ok_reg, m_ratio_ok_next;
    spo2rq_pkg::balance_t              m_balance_reg, m_balance_next;

    // shared multiplier
    logic [spo2rq_pkg::AC_BITS-1:0]    mul_a;
    logic [spo2rq_pkg::DC_BITS-1:0]    mul_b;
    logic [spo2rq_pkg::PROD_BITS-1:0]  mul_out;

    // divider
    logic                              div_start;
    logic [spo2rq_pkg::NUM_BITS-1:0]   div_num;
    logic                              div_done;
    logic [spo2rq_pkg::RATIO_BITS-1:0] div_quo;

    // quality slew
    logic                              q_up;
    logic [spo2rq_pkg::QUAL_BITS-1:0]  q_diff;
    logic [spo2rq_pkg::QUAL_BITS-1:0]  q_step;
    logic [spo2rq_pkg::QUAL_BITS-1:0]  q_slewed;

    // frame check and smoothing
    logic                              frame_ok;
    logic [spo2rq_pkg::RATIO_BITS+1:0] ema_sum;
    logic [spo2rq_pkg::RATIO_BITS-1:0] ratio_smooth;
    logic                              in_beat;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_valid && s_ready;

    assign mul_a   = (state_reg == S_MUL_P) ? red_ac_reg : ir_ac_reg;
    assign mul_b   = (state_reg == S_MUL_P) ? ir_lvl_reg : red_lvl_reg;
    assign mul_out = mul_a * mul_b;

    assign div_start = (state_reg == S_ADD);
    // rounding: add half the divisor
    assign div_num   = num_reg + spo2rq_pkg::NUM_BITS'(den_reg >> 1);

    spo2rq_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den_reg),
        .done    (div_done),
        .quo_sat (div_quo)
    );

    // symmetric slew, step never below 1
    assign q_up   = quality_reg < s_raw_score;
    assign q_diff = q_up ? (s_raw_score - quality_reg) : (quality_reg - s_raw_score);
    always_comb begin
        q_step = q_diff >> qshift_reg;
        if (q_step == '0) begin
            q_step = spo2rq_pkg::QUAL_BITS'(1);
        end
    end
    assign q_slewed = (quality_reg == s_raw_score) ? quality_reg
                    : (q_up ? (quality_reg + q_step) : (quality_reg - q_step));

    assign frame_ok = (s_red_level != '0) && (s_ir_level != '0) && (s_ir_ac != '0) &&
                      (s_red_ac >= min_ac_reg) && (s_ir_ac >= min_ac_reg);

    // (3*old + new + 2) / 4
    assign ema_sum = {2'b00, ratio_reg} + {1'b0, ratio_reg, 1'b0} +
                     {2'b00, div_quo} + (spo2rq_pkg::RATIO_BITS+2)'(2);
    assign ratio_smooth = (valid_reg || (ratio_reg != '0))
                        ? ema_sum[spo2rq_pkg::RATIO_BITS+1:2] : div_quo;

    always_comb begin
        state_next      = state_reg;
        low_limit_next  = low_limit_reg;
        high_limit_next = high_limit_reg;
        min_ac_next     = min_ac_reg;
        qshift_next     = qshift_reg;
        quality_next    = quality_reg;
        ratio_next      = ratio_reg;
        valid_next      = valid_reg;
        balance_next    = balance_reg;
        red_ac_next     = red_ac_reg;
        ir_ac_next      = ir_ac_reg;
        red_lvl_next    = red_lvl_reg;
        ir_lvl_next     = ir_lvl_reg;
        prod_next       = prod_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_quality_next  = m_quality_reg;
        m_ratio_next    = m_ratio_reg;
        m_ratio_ok_next = m_ratio_ok_reg;
        m_balance_next  = m_balance_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                spo2rq_pkg::CFG_LOW_LIMIT:     low_limit_next  = cfg_data;
                spo2rq_pkg::CFG_HIGH_LIMIT:    high_limit_next = cfg_data;
                spo2rq_pkg::CFG_MIN_AC_LEVEL:  min_ac_next     = cfg_data;
                spo2rq_pkg::CFG_QUALITY_SHIFT:
                    qshift_next = cfg_data[spo2rq_pkg::SHIFT_BITS-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    red_ac_next  = s_red_ac;
                    ir_ac_next   = s_ir_ac;
                    red_lvl_next = s_red_level;
                    ir_lvl_next  = s_ir_level;
                    if (s_op == spo2rq_pkg::OP_CLEAR) begin
                        quality_next = '0;
                        ratio_next   = '0;
                        valid_next   = 1'b0;
                        balance_next = spo2rq_pkg::BAL_UNKNOWN;
                        state_next   = S_DONE;
                    end else begin
                        quality_next = q_slewed;
                        if (frame_ok) begin
                            state_next = S_MUL_P;
                        end else begin
                            // ratio_reg is kept across a bad frame
                            valid_next   = 1'b0;
                            balance_next = spo2rq_pkg::BAL_UNKNOWN;
                            state_next   = S_DONE;
                        end
                    end
                end
            end
            S_MUL_P: begin
                prod_next  = mul_out;
                state_next = S_MUL_D;
            end
            S_MUL_D: begin
                den_next   = mul_out;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                // x1000 = x1024 - x32 + x8
                num_next = (spo2rq_pkg::NUM_BITS'(prod_reg) << 10) -
                           (spo2rq_pkg::NUM_BITS'(prod_reg) << 5) +
                           (spo2rq_pkg::NUM_BITS'(prod_reg) << 3);
                state_next = S_ADD;
            end
            S_ADD: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    ratio_next = ratio_smooth;
                    valid_next = 1'b1;
                    state_next = S_CLASS;
                end
            end
            S_CLASS: begin
                if (ratio_reg < low_limit_reg) begin
                    balance_next = spo2rq_pkg::BAL_LOW;
                end else if (ratio_reg > high_limit_reg) begin
                    balance_next = spo2rq_pkg::BAL_HIGH;
                end else begin
                    balance_next = spo2rq_pkg::BAL_OK;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                // publish once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_quality_next  = quality_reg;
                    m_ratio_next    = ratio_reg;
                    m_ratio_ok_next = valid_reg;
                    m_balance_next  = balance_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            low_limit_reg  <= spo2rq_pkg::LOW_LIMIT_RST;
            high_limit_reg <= spo2rq_pkg::HIGH_LIMIT_RST;
            min_ac_reg     <= spo2rq_pkg::MIN_AC_LEVEL_RST;
            qshift_reg     <= spo2rq_pkg::QUALITY_SHIFT_RST;
            quality_reg    <= '0;
            ratio_reg      <= '0;
            valid_reg      <= 1'b0;
            balance_reg    <= spo2rq_pkg::BAL_UNKNOWN;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            low_limit_reg  <= low_limit_next;
            high_limit_reg <= high_limit_next;
            min_ac_reg     <= min_ac_next;
            qshift_reg     <= qshift_next;
            quality_reg    <= quality_next;
            ratio_reg      <= ratio_next;
            valid_reg      <= valid_next;
            balance_reg    <= balance_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        red_ac_reg     <= red_ac_next;
        ir_ac_reg      <= ir_ac_next;
        red_lvl_reg    <= red_lvl_next;
        ir_lvl_reg     <= ir_lvl_next;
        prod_reg       <= prod_next;
        den_reg        <= den_next;
        num_reg        <= num_next;
        m_quality_reg  <= m_quality_next;
        m_ratio_reg    <= m_ratio_next;
        m_ratio_ok_reg <= m_ratio_ok_next;
        m_balance_reg  <= m_balance_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_quality  = m_quality_reg;
    assign m_ratio    = m_ratio_reg;
    assign m_ratio_ok = m_ratio_ok_reg;
    assign m_balance  = m_balance_reg;

    // a good ratio always carries a class; a bad one never does
    `SPO2RQ_ASSERT(a_ok_has_class, m_valid_reg && m_ratio_ok_reg |-> m_balance_reg != spo2rq_pkg::BAL_UNKNOWN, "valid ratio with unknown class")
    `SPO2RQ_ASSERT(a_bad_no_class, m_valid_reg && !m_ratio_ok_reg |-> m_balance_reg == spo2rq_pkg::BAL_UNKNOWN, "invalid ratio with a class")
    `SPO2RQ_ASSERT(a_div_done_state, div_done |-> state_reg == S_DIV, "divider finished outside divide wait")
    `SPO2RQ_ASSERT(a_result_from_done, $rose(m_valid_reg) |-> $past(state_reg) == S_DONE, "result raised outside publish step")

endmodule

// ===== rtl/spo2rq_div.sv =====
// ----------------------------------------------------------------------------
// spo2rq_div
// Restoring divider, one quotient bit per cycle, result saturated to 16 bits.
// ----------------------------------------------------------------------------
module spo2rq_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [spo2rq_pkg::NUM_BITS-1:0]       num,
    input  logic [spo2rq_pkg::PROD_BITS-1:0]      den,
    output logic                                  done,
    output logic [spo2rq_pkg::RATIO_BITS-1:0]     quo_sat
);

    localparam logic [spo2rq_pkg::CNT_BITS-1:0] LAST_STEP =
        spo2rq_pkg::CNT_BITS'(spo2rq_pkg::NUM_BITS - 1);

    logic                                 busy_reg, busy_next;
    logic                                 done_reg, done_next;
    logic [spo2rq_pkg::CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [spo2rq_pkg::PROD_BITS-1:0]     rem_reg, rem_next;
    logic [spo2rq_pkg::PROD_BITS-1:0]     den_reg, den_next;
    logic [spo2rq_pkg::NUM_BITS-1:0]      dvd_reg, dvd_next;
    logic [spo2rq_pkg::NUM_BITS-1:0]      quo_reg, quo_next;

    logic [spo2rq_pkg::PROD_BITS:0]       trial;
    logic [spo2rq_pkg::PROD_BITS:0]       trial_sub;
    logic                                 fits;

    assign trial     = {rem_reg, dvd_reg[spo2rq_pkg::NUM_BITS-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = den;
            dvd_next  = num;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = fits ? trial_sub[spo2rq_pkg::PROD_BITS-1:0]
                            : trial[spo2rq_pkg::PROD_BITS-1:0];
            dvd_next = dvd_reg << 1;
            quo_next = {quo_reg[spo2rq_pkg::NUM_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign done    = done_reg;
    // anything above 16 bits clamps to full scale
    assign quo_sat = (|quo_reg[spo2rq_pkg::NUM_BITS-1:spo2rq_pkg::RATIO_BITS])
                     ? spo2rq_pkg::RATIO_MAX
                     : quo_reg[spo2rq_pkg::RATIO_BITS-1:0];

endmodule
